// ----- rtl/gdr_pkg.sv -----
// gdr_pkg: shared types, codes and arithmetic helpers of the gated delta rule step
// used by every module of the block; depends on nothing

package gdr_pkg;

    // input beat as seen on the item channel
    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         head;
        logic [6:0]         key_index;
        logic [6:0]         row_index;
        logic signed [15:0] key_elem;
        logic signed [15:0] query_elem;
        logic signed [15:0] value_elem;
        logic signed [15:0] log_gate;
        logic signed [15:0] write_rate;
        logic               update_enable;
        logic signed [31:0] state_word;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic               kind;
        logic [1:0]         out_head;
        logic [6:0]         out_row;
        logic signed [31:0] out_value;
        logic               saturated;
    } out_item_t;

    // opcodes of the item channel
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ROW   = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // result kinds
    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // configuration register indexes
    localparam logic CFG_KEY_DIMS   = 1'b0;
    localparam logic CFG_VALUE_DIMS = 1'b1;
    localparam logic [7:0] DIMS_RESET = 8'd128;

    // command class decided by the front end
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_ROW,
        CMD_WRITE,
        CMD_READ
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t  op;
        logic     in_range;
        in_item_t item;
    } cmd_t;

    // back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

    // back end sequencer
    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_DISPATCH,
        B_READ,
        B_EXP,
        B_PASS,
        B_DRAIN,
        B_PROJ0,
        B_PROJ1,
        B_PROJ2,
        B_BD,
        B_DONE
    } back_state_t;

    // what a sweep over the row does
    typedef enum logic [1:0] {
        PASS_K,
        PASS_Q,
        PASS_UPD
    } pass_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

    // clamp to the signed 32-bit range
    function automatic sat_t sat32(input logic signed [47:0] v);
        sat_t r;
        r.ovf = 1'b0;
        r.val = signed'(v[31:0]);
        if (v > SAT_MAX)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end
        else if (v < SAT_MIN)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh80000000;
        end
        return r;
    endfunction

    // exp(-2^(b-11)) in Q1.30
    function automatic logic [30:0] exp_tab(input logic [3:0] b);
        logic [30:0] t;
        unique case (b)
            4'd0:    t = 31'd1073217664;
            4'd1:    t = 31'd1072693760;
            4'd2:    t = 31'd1071646719;
            4'd3:    t = 31'd1069555701;
            4'd4:    t = 31'd1065385899;
            4'd5:    t = 31'd1057095000;
            4'd6:    t = 31'd1040706256;
            4'd7:    t = 31'd1008687096;
            4'd8:    t = 31'd947573834;
            4'd9:    t = 31'd836230973;
            4'd10:   t = 31'd651257337;
            4'd11:   t = 31'd395007542;
            4'd12:   t = 31'd145315154;
            4'd13:   t = 31'd19666268;
            4'd14:   t = 31'd360200;
            default: t = 31'd121;
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/gdr_front.sv -----
// gdr_front: accepts item beats, classifies them and range checks them
// depends on gdr_pkg; feeds gdr_queue

module gdr_front #(
    parameter int HEADS         = 4,
    parameter int KEY_DIM_MAX   = 128,
    parameter int VALUE_DIM_MAX = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  gdr_pkg::in_item_t     item,
    input  logic [7:0]            value_dims_used,
    input  gdr_pkg::back_status_t status,
    input  logic                  q_ready,
    output logic                  q_push,
    output gdr_pkg::cmd_t         q_cmd
);

    logic accept;
    logic head_ok;
    logic row_ok;
    logic col_ok;
    logic row_used;
    logic drop;
    logic seen_reg;

    // beats stall while the queue is full, the state is being cleared or seen_reg is still low
    assign item_stall = !q_ready || status.clearing || !seen_reg;
    assign accept     = item_valid && !item_stall;

    // seen_reg holds beats off out of reset until it is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else
            seen_reg <= 1'b1;
    end

    // range checks against storage and rows in use
    always_comb
    begin
        head_ok  = int'(item.head) < HEADS;
        row_ok   = int'(item.row_index) < VALUE_DIM_MAX;
        col_ok   = int'(item.key_index) < KEY_DIM_MAX;
        row_used = row_ok && (int'(item.row_index) < int'(value_dims_used));
        q_cmd.item = item;
        q_cmd.op   = gdr_pkg::CMD_LOAD;
        q_cmd.in_range = 1'b0;
        drop = 1'b0;
        unique case (item.op)
            gdr_pkg::OP_LOAD:
            begin
                q_cmd.op = gdr_pkg::CMD_LOAD;
                q_cmd.in_range = col_ok;
                drop = !col_ok;
            end
            gdr_pkg::OP_ROW:
            begin
                q_cmd.op = gdr_pkg::CMD_ROW;
                q_cmd.in_range = head_ok && row_used;
            end
            gdr_pkg::OP_WRITE:
            begin
                q_cmd.op = gdr_pkg::CMD_WRITE;
                q_cmd.in_range = head_ok && row_ok && col_ok;
                drop = !(head_ok && row_ok && col_ok);
            end
            default:
            begin
                q_cmd.op = gdr_pkg::CMD_READ;
                q_cmd.in_range = head_ok && row_ok && col_ok;
            end
        endcase
        q_push = accept && !drop;
    end

endmodule

// ----- rtl/gdr_queue.sv -----
// gdr_queue: two-entry command queue between front and back end
// depends on gdr_pkg

module gdr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gdr_pkg::cmd_t push_cmd,
    output logic          ready,
    input  logic          pop,
    output logic          valid,
    output gdr_pkg::cmd_t pop_cmd
);

    gdr_pkg::cmd_t slot_reg [2];
    logic [1:0] count_reg;
    logic       wptr_reg;
    logic       rptr_reg;

    assign ready   = count_reg != 2'd2;
    assign valid   = count_reg != 2'd0;
    assign pop_cmd = slot_reg[rptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/gdr_back.sv -----
// gdr_back: sequencer holding the state matrices and key/query buffers,
// running the decay, projection, update and output sweeps; depends on gdr_pkg

module gdr_back #(
    parameter int HEADS         = 4,
    parameter int KEY_DIM_MAX   = 128,
    parameter int VALUE_DIM_MAX = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  gdr_pkg::cmd_t         q_cmd,
    output logic                  q_pop,
    input  logic [7:0]            key_dims_used,
    output gdr_pkg::back_status_t status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output gdr_pkg::out_item_t    result
);

    localparam int DEPTH = HEADS * VALUE_DIM_MAX * KEY_DIM_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (KEY_DIM_MAX > 1) ? $clog2(KEY_DIM_MAX) : 1;
    localparam int KCW   = $clog2(KEY_DIM_MAX + 1);

    // storage
    logic signed [31:0] mem [DEPTH];
    logic signed [15:0] kbuf [KEY_DIM_MAX];
    logic signed [15:0] qbuf [KEY_DIM_MAX];
    logic signed [31:0] mem_q;
    logic signed [15:0] kb_q;
    logic signed [15:0] qb_q;

    // control
    gdr_pkg::back_state_t state_reg, state_next;
    gdr_pkg::pass_t       pass_reg;
    gdr_pkg::cmd_t        cmd_reg;
    logic [AW-1:0]        base_reg;
    logic [AW-1:0]        clr_reg;
    logic [KCW-1:0]       i_reg;
    logic [KCW-1:0]       kd;
    logic [3:0]           bit_reg;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 out_valid_reg;
    gdr_pkg::out_item_t   out_reg;

    // datapath
    logic [30:0]          e_reg;
    logic signed [55:0]   acc_reg;
    logic                 sat_reg;
    logic signed [31:0]   res_reg;
    logic signed [63:0]   ep_reg;
    logic signed [50:0]   bdp_reg;
    logic signed [37:0]   bd_reg;
    logic signed [63:0]   pe_reg;
    logic signed [53:0]   pk_reg;
    logic signed [31:0]   r2_reg;
    logic signed [15:0]   vec2_reg;
    logic [AW-1:0]        a1_reg, a2_reg;
    logic signed [31:0]   rn3_reg;
    logic signed [15:0]   vec3_reg;
    logic signed [47:0]   prod4_reg;

    // strobes
    logic                 issue;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic signed [31:0]   mem_wd;
    logic                 buf_we;
    logic [AW-1:0]        rd_addr;
    logic                 deliver;
    logic                 pipe_busy;

    // combinational datapath terms
    logic [15:0]          gate_mag;
    logic [61:0]          exp_prod;
    logic [61:0]          exp_sum;
    logic signed [31:0]   e_s;
    logic signed [63:0]   pe_sum;
    logic signed [53:0]   pk_sum;
    logic signed [41:0]   upd_sum;
    gdr_pkg::sat_t        upd_sat;
    logic signed [31:0]   rn;
    logic                 upd;
    logic signed [55:0]   acc_sum;
    gdr_pkg::sat_t        acc_sat;
    logic signed [63:0]   ep_sum;
    logic signed [34:0]   d;
    logic signed [50:0]   bdp_sum;
    logic [AW-1:0]        elem_addr;

    assign status.clearing = state_reg == gdr_pkg::B_CLEAR;
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;
    assign pipe_busy       = v1_reg || v2_reg || v3_reg || v4_reg;
    assign kd = (int'(key_dims_used) > KEY_DIM_MAX) ? KCW'(KEY_DIM_MAX) : KCW'(key_dims_used);
    assign elem_addr = base_reg + AW'(cmd_reg.item.key_index);

    // exponential step, gate magnitude and shared arithmetic
    always_comb
    begin
        gate_mag = cmd_reg.item.log_gate[15] ? 16'(-cmd_reg.item.log_gate) : 16'd0;
        exp_prod = 62'(e_reg) * 62'(gdr_pkg::exp_tab(bit_reg));
        exp_sum  = exp_prod + (62'd1 << 29);
        e_s      = signed'({1'b0, e_reg});
        upd      = pass_reg == gdr_pkg::PASS_UPD;
        pe_sum   = pe_reg + (64'sd1 <<< 29);
        pk_sum   = pk_reg + (54'sd1 <<< 12);
        upd_sum  = 42'(signed'(pe_sum[63:30])) + 42'(signed'(pk_sum[53:13]));
        upd_sat  = gdr_pkg::sat32(48'(upd_sum));
        rn       = upd ? upd_sat.val : r2_reg;
        acc_sum  = acc_reg + (56'sd1 <<< 12);
        acc_sat  = gdr_pkg::sat32(48'(signed'(acc_sum[55:13])));
        ep_sum   = ep_reg + (64'sd1 <<< 29);
        d        = (35'(cmd_reg.item.value_elem) <<< 10) - 35'(signed'(ep_sum[63:30]));
        bdp_sum  = bdp_reg + (51'sd1 <<< 12);
    end

    // next state and strobes
    always_comb
    begin
        state_next = state_reg;
        q_pop   = 1'b0;
        issue   = 1'b0;
        mem_we  = 1'b0;
        mem_wa  = a2_reg;
        mem_wd  = rn;
        buf_we  = 1'b0;
        rd_addr = elem_addr;
        deliver = 1'b0;
        if (v2_reg && upd)
            mem_we = 1'b1;
        unique case (state_reg)
            gdr_pkg::B_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = '0;
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = gdr_pkg::B_IDLE;
            end
            gdr_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = gdr_pkg::B_DISPATCH;
                end
            end
            gdr_pkg::B_DISPATCH:
            begin
                unique case (cmd_reg.op)
                    gdr_pkg::CMD_LOAD:
                    begin
                        buf_we = 1'b1;
                        state_next = gdr_pkg::B_IDLE;
                    end
                    gdr_pkg::CMD_WRITE:
                    begin
                        mem_we = 1'b1;
                        mem_wa = elem_addr;
                        mem_wd = cmd_reg.item.state_word;
                        state_next = gdr_pkg::B_IDLE;
                    end
                    gdr_pkg::CMD_READ:
                        state_next = cmd_reg.in_range ? gdr_pkg::B_READ : gdr_pkg::B_DONE;
                    default:
                    begin
                        if (!cmd_reg.in_range)
                            state_next = gdr_pkg::B_DONE;
                        else if (cmd_reg.item.update_enable)
                            state_next = gdr_pkg::B_EXP;
                        else
                            state_next = gdr_pkg::B_PASS;
                    end
                endcase
            end
            gdr_pkg::B_READ:
                state_next = gdr_pkg::B_DONE;
            gdr_pkg::B_EXP:
            begin
                if (bit_reg == 4'd15)
                    state_next = gdr_pkg::B_PASS;
            end
            gdr_pkg::B_PASS:
            begin
                rd_addr = base_reg + AW'(i_reg);
                if (i_reg < kd)
                    issue = 1'b1;
                else
                    state_next = gdr_pkg::B_DRAIN;
            end
            gdr_pkg::B_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = (pass_reg == gdr_pkg::PASS_K) ? gdr_pkg::B_PROJ0
                                                               : gdr_pkg::B_DONE;
            end
            gdr_pkg::B_PROJ0:
                state_next = gdr_pkg::B_PROJ1;
            gdr_pkg::B_PROJ1:
                state_next = gdr_pkg::B_PROJ2;
            gdr_pkg::B_PROJ2:
                state_next = gdr_pkg::B_BD;
            gdr_pkg::B_BD:
                state_next = gdr_pkg::B_PASS;
            default:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    deliver = 1'b1;
                    state_next = gdr_pkg::B_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdr_pkg::B_CLEAR;
            clr_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gdr_pkg::B_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (deliver)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // state matrix and token buffers
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            kbuf[KW'(cmd_reg.item.key_index)] <= cmd_reg.item.key_elem;
            qbuf[KW'(cmd_reg.item.key_index)] <= cmd_reg.item.query_elem;
        end
        kb_q <= kbuf[i_reg[KW-1:0]];
        qb_q <= qbuf[i_reg[KW-1:0]];
    end

    // sweep pipeline: products, update and saturation, output product
    always_ff @(posedge clk)
    begin
        a1_reg    <= rd_addr;
        a2_reg    <= a1_reg;
        pe_reg    <= 64'(e_s) * 64'(mem_q);
        pk_reg    <= 54'(bd_reg) * 54'(kb_q);
        r2_reg    <= mem_q;
        vec2_reg  <= (pass_reg == gdr_pkg::PASS_K) ? kb_q : qb_q;
        rn3_reg   <= rn;
        vec3_reg  <= vec2_reg;
        prod4_reg <= 48'(rn3_reg) * 48'(vec3_reg);
    end

    // sequencer payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg  <= q_cmd;
            base_reg <= AW'((int'(q_cmd.item.head) * VALUE_DIM_MAX
                            + int'(q_cmd.item.row_index)) * KEY_DIM_MAX);
        end
        if (v4_reg)
            acc_reg <= acc_reg + 56'(prod4_reg);
        if (v2_reg && upd && upd_sat.ovf)
            sat_reg <= 1'b1;
        if (issue)
            i_reg <= i_reg + KCW'(1);
        unique case (state_reg)
            gdr_pkg::B_DISPATCH:
            begin
                sat_reg  <= 1'b0;
                res_reg  <= '0;
                acc_reg  <= '0;
                i_reg    <= '0;
                e_reg    <= 31'd1 << 30;
                bit_reg  <= 4'd0;
                pass_reg <= cmd_reg.item.update_enable ? gdr_pkg::PASS_K : gdr_pkg::PASS_Q;
            end
            gdr_pkg::B_READ:
                res_reg <= mem_q;
            gdr_pkg::B_EXP:
            begin
                if (gate_mag[bit_reg])
                    e_reg <= exp_sum[60:30];
                bit_reg <= bit_reg + 4'd1;
            end
            gdr_pkg::B_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    res_reg <= acc_sat.val;
                    if (acc_sat.ovf)
                        sat_reg <= 1'b1;
                end
            end
            gdr_pkg::B_PROJ1:
                ep_reg <= 64'(e_s) * 64'(res_reg);
            gdr_pkg::B_PROJ2:
                bdp_reg <= 51'(cmd_reg.item.write_rate) * 51'(d);
            gdr_pkg::B_BD:
            begin
                bd_reg   <= signed'(bdp_sum[50:13]);
                acc_reg  <= '0;
                i_reg    <= '0;
                pass_reg <= gdr_pkg::PASS_UPD;
            end
            default:
            begin
            end
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            out_reg.kind      <= (cmd_reg.op == gdr_pkg::CMD_READ) ? gdr_pkg::KIND_READ
                                                                   : gdr_pkg::KIND_ROW;
            out_reg.out_head  <= cmd_reg.item.head;
            out_reg.out_row   <= cmd_reg.item.row_index;
            out_reg.out_value <= res_reg;
            out_reg.saturated <= sat_reg;
        end
    end

endmodule

// ----- rtl/gated_delta_rule_recurrent_step.sv -----
// gated_delta_rule_recurrent_step: top level with configuration registers,
// front end, command queue and back end; depends on gdr_pkg, gdr_front, gdr_queue and gdr_back
//
// Usage
// - item channel (item_valid, item_stall, item) carries one op per beat:
//   load key/query element, process value row, write state word, read state word
// - result channel (result_valid, result_stall, result) returns one beat for
//   row and read ops, none for load and write ops, in input order
// - cfg_write with cfg_index / cfg_data sets key_dims_used and value_dims_used;
//   write only while the block is idle
// - after reset the back end zeroes every state word, one per cycle, over all
//   HEADS*VALUE_DIM_MAX*KEY_DIM_MAX words (65536 at the defaults); item_stall
//   stays high until the clearing is done
// - in the back end a row without update sweeps the key elements in use against
//   the query; with update it forms the decay from the gate bits, sweeps against
//   the key, projects, and sweeps again to write the row and take its query product;
//   one state word per cycle through the single memory read port sets the sweep time
// - a two-entry queue takes new beats while the back end works; the result
//   register holds a finished beat while the receiver stalls, and the back end
//   waits only when it has a second result to hand over

module gated_delta_rule_recurrent_step #(
    parameter int HEADS         = 4,
    parameter int KEY_DIM_MAX   = 128,
    parameter int VALUE_DIM_MAX = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  gdr_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output gdr_pkg::out_item_t result,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);

    logic [7:0]            key_dims_reg;
    logic [7:0]            value_dims_reg;
    gdr_pkg::back_status_t status;
    gdr_pkg::cmd_t         push_cmd;
    gdr_pkg::cmd_t         pop_cmd;
    logic                  q_push;
    logic                  q_ready;
    logic                  q_pop;
    logic                  q_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_dims_reg   <= gdr_pkg::DIMS_RESET;
            value_dims_reg <= gdr_pkg::DIMS_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == gdr_pkg::CFG_KEY_DIMS)
                key_dims_reg <= cfg_data;
            else if (cfg_index == gdr_pkg::CFG_VALUE_DIMS)
                value_dims_reg <= cfg_data;
        end
    end

    gdr_front #(
        .HEADS         (HEADS),
        .KEY_DIM_MAX   (KEY_DIM_MAX),
        .VALUE_DIM_MAX (VALUE_DIM_MAX)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .value_dims_used (value_dims_reg),
        .status          (status),
        .q_ready         (q_ready),
        .q_push          (q_push),
        .q_cmd           (push_cmd)
    );

    gdr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    gdr_back #(
        .HEADS         (HEADS),
        .KEY_DIM_MAX   (KEY_DIM_MAX),
        .VALUE_DIM_MAX (VALUE_DIM_MAX)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .key_dims_used (key_dims_reg),
        .status        (status),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

endmodule

// ----- rtl/gdr_checker.sv -----
// gdr_checker: port-level assertions for the gated delta rule step
// depends on gdr_pkg; bound to gated_delta_rule_recurrent_step

module gdr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input gdr_pkg::out_item_t result
);

    // a stalled result beat stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // readbacks never flag saturation
    a_read_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == gdr_pkg::KIND_READ) |-> !result.saturated)
        else $error("readback flagged saturation");

    // state clearing holds off items right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> item_stall)
        else $error("item taken during state clearing");

    // no result right after reset, while the state is being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !result_valid)
        else $error("result shown during state clearing");

endmodule

bind gated_delta_rule_recurrent_step gdr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
